FILE: rtl/palette_pixel_replication_scaler_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the palette pixel replication scaler
// Each macro checks one clocked property and reports through $error.
// ---------------------------------------------------------------------------
`ifndef PALETTE_PIXEL_REPLICATION_SCALER_CORE_ASSERT_SVH
`define PALETTE_PIXEL_REPLICATION_SCALER_CORE_ASSERT_SVH

// same-cycle implication
`define PPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ppr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppr_pkg
// Shared constants, types and the axis and geometry fit functions for the scaler.
// ---------------------------------------------------------------------------
package ppr_pkg;

  localparam int SRC_WIDTH    = 320;
  localparam int SRC_HEIGHT   = 240;
  localparam int COLOR_BITS   = 16;
  localparam int PALETTE_SIZE = 256;
  localparam int MAX_SCALE    = 8;

  localparam int PAL_BITS = (COLOR_BITS < 16) ? COLOR_BITS : 16;
  localparam int PAL_AW   = $clog2(PALETTE_SIZE);
  localparam int COL_W    = $clog2(SRC_WIDTH);
  localparam int ROW_W    = $clog2(SRC_HEIGHT);
  localparam int COPY_W   = $clog2(MAX_SCALE);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT = 1'b1;

  localparam logic REQ_PALETTE = 1'b0;
  localparam logic REQ_PIXEL   = 1'b1;

  localparam logic [11:0] DISP_W_RESET = 12'd320;
  localparam logic [10:0] DISP_H_RESET = 11'd240;

  typedef struct packed {
    logic [3:0]  scale;
    logic [11:0] offset;
  } axis_t;

  typedef struct packed {
    logic [3:0]  xs;
    logic [11:0] xo;
    logic [3:0]  ys;
    logic [10:0] yo;
    logic        too_small;
  } geom_t;

  typedef struct packed {
    logic [11:0] base_x;
    logic [10:0] dest_y;
    logic        too_small;
    logic [15:0] color;
  } pix_t;

  // scale = min(size / src, MAX_SCALE), offset = half the leftover
  function automatic axis_t axis_fit(input logic [11:0] size, input logic [10:0] src);
    axis_t      r;
    logic [13:0] span;
    r.scale = '0;
    for (int k = 1; k <= MAX_SCALE; k++) begin
      if (14'(size) >= 14'(k) * 14'(src)) r.scale = 4'(k);
    end
    span     = 14'(size) - 14'(r.scale) * 14'(src);
    r.offset = 12'(span >> 1);
    return r;
  endfunction

  function automatic geom_t geom_fit(input logic [11:0] w, input logic [10:0] h);
    geom_t g;
    axis_t ax;
    axis_t ay;
    ax = axis_fit(w, 11'(SRC_WIDTH));
    ay = axis_fit(12'(h), 11'(SRC_HEIGHT));
    g.xs = ax.scale;
    g.xo = ax.offset;
    g.ys = ay.scale;
    g.yo = 11'(ay.offset);
    g.too_small = (w < 12'(SRC_WIDTH)) || (h < 11'(SRC_HEIGHT));
    return g;
  endfunction

endpackage

FILE: rtl/ppr_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppr_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module ppr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: rtl/ppr_cfg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppr_cfg
// Display size registers and the registered scale and offset per axis.
// ---------------------------------------------------------------------------
module ppr_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ppr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [11:0]                    cfg_data,
  output ppr_pkg::geom_t                 geom
);

  logic [11:0] display_width;
  logic [10:0] display_height;
  logic [11:0] display_width_next;
  logic [10:0] display_height_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    display_width_next  = display_width;
    display_height_next = display_height;
    if (cfg_valid) begin
      unique case (cfg_index)
        ppr_pkg::REG_DISPLAY_WIDTH:  display_width_next  = cfg_data;
        ppr_pkg::REG_DISPLAY_HEIGHT: display_height_next = cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // fit from the next values so the geometry is ready at the write edge
  always_ff @(posedge clk) begin
    if (rst) begin
      display_width  <= ppr_pkg::DISP_W_RESET;
      display_height <= ppr_pkg::DISP_H_RESET;
      geom           <= ppr_pkg::geom_fit(ppr_pkg::DISP_W_RESET, ppr_pkg::DISP_H_RESET);
    end else begin
      display_width  <= display_width_next;
      display_height <= display_height_next;
      geom           <= ppr_pkg::geom_fit(display_width_next, display_height_next);
    end
  end

endmodule

FILE: rtl/ppr_emit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppr_emit
// Copy emitter: sends one horizontal copy per cycle into the output register unless it is stalled.
// ---------------------------------------------------------------------------
`include "palette_pixel_replication_scaler_core_assert.svh"

module ppr_emit (
  input  logic           clk,
  input  logic           rst,
  input  logic           s1_valid,
  input  ppr_pkg::pix_t  pix,
  input  ppr_pkg::geom_t geom,
  output logic           take,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [11:0]    dest_x,
  output logic [10:0]    dest_y,
  output logic [3:0]     row_count,
  output logic [15:0]    color,
  output logic           too_small,
  output logic           last
);

  logic [ppr_pkg::COPY_W-1:0] x;
  logic                       load;
  logic                       is_last;

  assign load    = s1_valid && (!out_valid || out_ready);
  assign is_last = pix.too_small || (4'({1'b0, x}) + 4'd1 == geom.xs);
  assign take    = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      x         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        x         <= is_last ? '0 : x + 1'b1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      too_small <= pix.too_small;
      last      <= is_last;
      if (pix.too_small) begin
        dest_x    <= '0;
        dest_y    <= '0;
        row_count <= '0;
        color     <= '0;
      end else begin
        dest_x    <= pix.base_x + 12'(x);
        dest_y    <= pix.dest_y;
        row_count <= geom.ys;
        color     <= pix.color;
      end
    end
  end

  `PPR_ASSERT_NOW(a_err_is_last, out_valid && too_small, last, "error word without last")
  `PPR_ASSERT_NOW(a_copy_in_range, s1_valid && !pix.too_small, 4'({1'b0, x}) < geom.xs,
    "copy index beyond scale")
  `PPR_ASSERT_NEXT(a_hold_on_stall, out_valid && !out_ready, $stable(x) && out_valid,
    "copy index moved while output stalled")

endmodule

FILE: rtl/palette_pixel_replication_scaler_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// palette_pixel_replication_scaler_core
// Palette lookup and integer pixel replication onto a larger display.
// ---------------------------------------------------------------------------
// A palette write gives no word. A source pixel gives xs words, xs being
// the horizontal scale (1 to 8, from the display width), or a single error
// word when the display is smaller than the source. The copy emitter sends
// one output word per cycle, unless the output stalls, from a single output
// register, and the next pixel is taken in the cycle its last copy is loaded
// into that register. A taken pixel is registered in the s1 stage, then its
// words in the output register; output stalls hold the pixel in place.
// The palette RAM has no reset; entries must be written before pixels use them.
// Scale and offset are refit at the edge of a display size write.

module palette_pixel_replication_scaler_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ppr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [11:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [7:0]                    palette_index,
  input  logic [15:0]                   palette_color,
  input  logic [7:0]                    pixel_index,
  input  logic                          frame_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [11:0]                   dest_x,
  output logic [10:0]                   dest_y,
  output logic [3:0]                    row_count,
  output logic [15:0]                   color,
  output logic                          too_small,
  output logic                          last
);

  ppr_pkg::geom_t geom;
  ppr_pkg::pix_t  pix;

  logic                         accept;
  logic                         pix_acc;
  logic                         pal_we;
  logic                         take;
  logic [ppr_pkg::PAL_BITS-1:0] ram_rdata;

  logic [ppr_pkg::COL_W-1:0] col;
  logic [ppr_pkg::ROW_W-1:0] row;
  logic [ppr_pkg::COL_W-1:0] col_cur;
  logic [ppr_pkg::ROW_W-1:0] row_cur;
  logic [13:0]               base_x_wide;
  logic [13:0]               dest_y_wide;

  logic        s1_valid;
  logic [11:0] s1_base_x;
  logic [10:0] s1_dest_y;
  logic        s1_too_small;
  logic        s1_color_ok;

  assign in_ready = !s1_valid || take;
  assign accept   = in_valid && in_ready;
  assign pix_acc  = accept && (req_type == ppr_pkg::REQ_PIXEL);
  assign pal_we   = accept && (req_type == ppr_pkg::REQ_PALETTE) &&
                    ({1'b0, palette_index} < 9'(ppr_pkg::PALETTE_SIZE));

  ppr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  ppr_ram #(
    .WIDTH (ppr_pkg::PAL_BITS),
    .DEPTH (ppr_pkg::PALETTE_SIZE)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (palette_index[ppr_pkg::PAL_AW-1:0]),
    .wdata (palette_color[ppr_pkg::PAL_BITS-1:0]),
    .re    (pix_acc),
    .raddr (pixel_index[ppr_pkg::PAL_AW-1:0]),
    .rdata (ram_rdata)
  );

  // start of frame restarts the raster before this pixel
  assign col_cur     = frame_start ? '0 : col;
  assign row_cur     = frame_start ? '0 : row;
  assign base_x_wide = 14'(geom.xo) + 14'(col_cur) * 14'(geom.xs);
  assign dest_y_wide = 14'(geom.yo) + 14'(row_cur) * 14'(geom.ys);

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= pix_acc;
      if (pix_acc) begin
        if (col_cur == ppr_pkg::COL_W'(ppr_pkg::SRC_WIDTH - 1)) begin
          col <= '0;
          row <= (row_cur == ppr_pkg::ROW_W'(ppr_pkg::SRC_HEIGHT - 1)) ? '0
                                                                        : row_cur + 1'b1;
        end else begin
          col <= col_cur + 1'b1;
          row <= row_cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_base_x    <= base_x_wide[11:0];
      s1_dest_y    <= dest_y_wide[10:0];
      s1_too_small <= geom.too_small;
      s1_color_ok  <= {1'b0, pixel_index} < 9'(ppr_pkg::PALETTE_SIZE);
    end
  end

  always_comb begin
    pix.base_x    = s1_base_x;
    pix.dest_y    = s1_dest_y;
    pix.too_small = s1_too_small;
    pix.color     = s1_color_ok ? 16'(ram_rdata) : '0;
  end

  ppr_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .pix       (pix),
    .geom      (geom),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dest_x    (dest_x),
    .dest_y    (dest_y),
    .row_count (row_count),
    .color     (color),
    .too_small (too_small),
    .last      (last)
  );

endmodule
